// ----- hdl/mnp_pkg.sv -----
// mnp_pkg: shared types, sizes and helpers for the midi note pairing block
// no dependencies; used by mnp_ctrl, mnp_datapath and midi_note_pairing
package mnp_pkg;

    localparam int NOTE_COUNT = 128;
    localparam int PULSE_BITS = 32;
    localparam int IDX_W      = (NOTE_COUNT > 1) ? $clog2(NOTE_COUNT) : 1;
    localparam int ENTRY_W    = PULSE_BITS + 4 + 7;

    typedef enum logic [1:0] {
        MODE_OTHER = 2'd0,
        MODE_ON    = 2'd1,
        MODE_OFF   = 2'd2
    } t_mode;

    typedef enum logic {
        S_IDLE,
        S_RESOLVE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic commit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic hit;
        logic out_blocked;
    } t_sts;

    // 32-bit event pulse to stored pulse width
    function automatic logic [PULSE_BITS-1:0] to_pulse(input logic [31:0] p);
        logic [PULSE_BITS+31:0] wide;
        wide = {{PULSE_BITS{1'b0}}, p};
        return wide[PULSE_BITS-1:0];
    endfunction

    // stored pulse back to the 32-bit field
    function automatic logic [31:0] from_pulse(input logic [PULSE_BITS-1:0] p);
        logic [PULSE_BITS+31:0] wide;
        wide = {32'd0, p};
        return wide[31:0];
    endfunction

endpackage

// ----- hdl/midi_note_pairing.sv -----
// midi_note_pairing: top level, pairs note-on and note-off events into finished notes
// depends on mnp_pkg, mnp_ctrl and mnp_datapath
//
//  channel  | handshake           | word
//  ---------+---------------------+--------------------------------------------------
//  event in | i_valid / o_stall   | mode, note number, velocity, channel, pulse
//  note out | o_valid / i_stall   | note, start pulse, end pulse, channel, velocity
//
// each event word is handled in two steps: capture it and read the note table,
// then resolve it against the active flag and update the table
// the note table has a single registered read port, which is why capture and resolve are separate steps
// a finished note sits in an output register, so the next event is taken while it waits
// resolve holds only when a note must close while the output register is still stalled
// reset clears the active flags and the output valid at once, no clearing pass
module midi_note_pairing (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // event channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_mode,
    input  logic [6:0]  i_note_number,
    input  logic [6:0]  i_velocity,
    input  logic [3:0]  i_channel,
    input  logic [31:0] i_event_pulse,
    // finished note channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [6:0]  o_closed_note,
    output logic [31:0] o_start_pulse,
    output logic [31:0] o_end_pulse,
    output logic [3:0]  o_closed_channel,
    output logic [6:0]  o_closed_velocity
);

    // command and status between sequencer and datapath
    mnp_pkg::t_cmd cmd;
    mnp_pkg::t_sts sts;

    // sequencer: idle accepts a word, resolve commits it
    mnp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // datapath: table of sounding notes and the output register
    mnp_datapath u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_mode            (i_mode),
        .i_note_number     (i_note_number),
        .i_velocity        (i_velocity),
        .i_channel         (i_channel),
        .i_event_pulse     (i_event_pulse),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_closed_note     (o_closed_note),
        .o_start_pulse     (o_start_pulse),
        .o_end_pulse       (o_end_pulse),
        .o_closed_channel  (o_closed_channel),
        .o_closed_velocity (o_closed_velocity)
    );

endmodule

// ----- hdl/mnp_ctrl.sv -----
// mnp_ctrl: two-state sequencer for the midi note pairing block
// depends on mnp_pkg
module mnp_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  mnp_pkg::t_sts i_sts,
    output mnp_pkg::t_cmd o_cmd
);

    mnp_pkg::t_state r_state;
    mnp_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mnp_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_stall       = 1'b1;
        o_cmd.capture = 1'b0;
        o_cmd.commit  = 1'b0;
        unique case (r_state)
            mnp_pkg::S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = mnp_pkg::S_RESOLVE;
                end
            end
            mnp_pkg::S_RESOLVE: begin
                // hold while a finished note cannot be handed on
                if (!(i_sts.hit && i_sts.out_blocked)) begin
                    o_cmd.commit = 1'b1;
                    n_state      = mnp_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = mnp_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ----- hdl/mnp_datapath.sv -----
// mnp_datapath: event registers, note table, active flags and output register
// depends on mnp_pkg
module mnp_datapath (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  mnp_pkg::t_cmd i_cmd,
    output mnp_pkg::t_sts o_sts,
    input  logic [1:0]    i_mode,
    input  logic [6:0]    i_note_number,
    input  logic [6:0]    i_velocity,
    input  logic [3:0]    i_channel,
    input  logic [31:0]   i_event_pulse,
    output logic          o_valid,
    input  logic          i_stall,
    output logic [6:0]    o_closed_note,
    output logic [31:0]   o_start_pulse,
    output logic [31:0]   o_end_pulse,
    output logic [3:0]    o_closed_channel,
    output logic [6:0]    o_closed_velocity
);

    // captured event
    logic [1:0]                    r_mode;
    logic [6:0]                    r_key;
    logic [6:0]                    r_vel;
    logic [3:0]                    r_chan;
    logic [mnp_pkg::PULSE_BITS-1:0] r_pulse;

    // note table: start pulse, channel, velocity
    logic [mnp_pkg::ENTRY_W-1:0] mem [mnp_pkg::NOTE_COUNT];
    logic [mnp_pkg::ENTRY_W-1:0] r_rd;
    logic                        r_active [mnp_pkg::NOTE_COUNT];
    logic                        r_active_rd;

    logic                         r_out_valid;
    logic [6:0]                   r_out_note;
    logic [31:0]                  r_out_start;
    logic [31:0]                  r_out_end;
    logic [3:0]                   r_out_chan;
    logic [6:0]                   r_out_vel;

    logic [mnp_pkg::IDX_W-1:0] key_idx;
    logic                      relevant;
    logic                      opens;
    logic                      hit;

    assign key_idx  = r_key[mnp_pkg::IDX_W-1:0];
    assign relevant = (r_mode == mnp_pkg::MODE_ON || r_mode == mnp_pkg::MODE_OFF)
                      && ({1'b0, r_key} < 8'(mnp_pkg::NOTE_COUNT));
    assign opens    = relevant && (r_mode == mnp_pkg::MODE_ON) && (r_vel != 7'd0);
    assign hit      = relevant && r_active_rd;

    assign o_sts.hit         = hit;
    assign o_sts.out_blocked = r_out_valid && i_stall;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode      <= i_mode;
            r_key       <= i_note_number;
            r_vel       <= i_velocity;
            r_chan      <= i_channel;
            r_pulse     <= mnp_pkg::to_pulse(i_event_pulse);
            r_rd        <= mem[i_note_number[mnp_pkg::IDX_W-1:0]];
            r_active_rd <= r_active[i_note_number[mnp_pkg::IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && opens) begin
            mem[key_idx] <= {r_pulse, r_chan, r_vel};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < mnp_pkg::NOTE_COUNT; k++) begin
                r_active[k] <= 1'b0;
            end
        end else if (i_cmd.commit && relevant) begin
            // retrigger: close then reopen leaves the flag set
            r_active[key_idx] <= opens;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit && hit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && hit) begin
            r_out_note  <= r_key;
            r_out_start <= mnp_pkg::from_pulse(r_rd[mnp_pkg::ENTRY_W-1 -: mnp_pkg::PULSE_BITS]);
            r_out_end   <= mnp_pkg::from_pulse(r_pulse);
            r_out_chan  <= r_rd[10:7];
            r_out_vel   <= r_rd[6:0];
        end
    end

    assign o_valid           = r_out_valid;
    assign o_closed_note     = r_out_note;
    assign o_start_pulse     = r_out_start;
    assign o_end_pulse       = r_out_end;
    assign o_closed_channel  = r_out_chan;
    assign o_closed_velocity = r_out_vel;

endmodule
